// ----- rtl/core/pva_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pva_pkg
// Types, codes and defaults shared by the voice allocator modules.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int CHANNELS_DEFAULT      = 32;
   localparam int SOUND_SLOTS_DEFAULT   = 256;
   localparam int PRIORITY_BITS_DEFAULT = 8;

   localparam logic [2:0] REQ_LOAD    = 3'd0;
   localparam logic [2:0] REQ_PLAY    = 3'd1;
   localparam logic [2:0] REQ_STOP    = 3'd2;
   localparam logic [2:0] REQ_UNLOAD  = 3'd3;
   localparam logic [2:0] REQ_CLEANUP = 3'd4;

   localparam logic [2:0] CSR_MAX_CHANNELS = 3'd0;
   localparam logic [2:0] CSR_MASTER_GAIN  = 3'd1;
   localparam logic [2:0] CSR_EFFECTS_GAIN = 3'd2;
   localparam logic [2:0] CSR_SPEECH_GAIN  = 3'd3;
   localparam logic [2:0] CSR_MUSIC_GAIN   = 3'd4;

   localparam logic [1:0] CAT_SPEECH = 2'd1;
   localparam logic [1:0] CAT_MUSIC  = 2'd2;

   localparam logic       ACT_START = 1'b0;
   localparam logic       ACT_STOP  = 1'b1;

   localparam logic [5:0] MAX_CHANNELS_RESET = 6'd32;
   localparam logic [8:0] GAIN_RESET         = 9'd256;
   localparam logic [8:0] GAIN_UNITY         = 9'd256;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] sound_id;
      logic [7:0] priority_in;
      logic       loop_in;
      logic [8:0] event_gain;
      logic [1:0] category;
   } req_type_type;

   typedef struct packed {
      logic       action;
      logic [7:0] out_sound_id;
      logic [8:0] out_gain;
      logic       out_loop;
      logic [5:0] active_count;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      SCAN_MIN   = 2'd0,
      SCAN_REMAT = 2'd1,
      SCAN_REMID = 2'd2,
      SCAN_CLEAN = 2'd3
   } scan_mode_type;

   typedef struct packed {
      logic          capture;
      logic          set_loaded;
      logic          clr_loaded;
      logic          scan_init;
      logic          scan_rd;
      logic          scan_ld;
      logic          scan_ev;
      logic          scan_fin;
      scan_mode_type mode;
      logic          gain1;
      logic          gain2;
      logic          emit_victim;
      logic          emit_req_stop;
      logic          emit_start;
   } cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic [2:0] req_type;
      logic       hit;
      logic       evict;
      logic       scan_end;
      logic       out_free;
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/core/priority_voice_allocator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// priority_voice_allocator_unit
// Sound voice bookkeeping with priority-based voice stealing.
// ----------------------------------------------------------------------------
// One request is handled at a time; its first cycle reads the loaded map. A load,
// an ignored request or a play of an unloaded sound ends after the check step; a
// play with room goes on through the gain steps to its start result. Stop and
// unload of a loaded sound, and cleanup, walk the voice table, reading, looking
// up and evaluating each entry in turn, and a play on a full table walks it twice
// (search, then removal). After reset the loaded map is cleared slot by slot, and
// no request is taken until that is done.
module priority_voice_allocator_unit #(
   parameter int CHANNELS      = pva_pkg::CHANNELS_DEFAULT,
   parameter int SOUND_SLOTS   = pva_pkg::SOUND_SLOTS_DEFAULT,
   parameter int PRIORITY_BITS = pva_pkg::PRIORITY_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pva_pkg::req_type_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pva_pkg::rsp_type           rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [2:0]            csr_index,
   input  wire logic [8:0]            csr_wdata
);

   pva_pkg::cmd_type    cmd;
   pva_pkg::status_type sts;

   pva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pva_datapath #(
      .CHANNELS      (CHANNELS),
      .SOUND_SLOTS   (SOUND_SLOTS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
`default_nettype wire

// ----- rtl/core/pva_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pva_ctrl
// Sequencer that steps the datapath through lookup, table scans and results.
// ----------------------------------------------------------------------------
module pva_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pva_pkg::status_type sts,
   output pva_pkg::cmd_type        cmd
);

   typedef enum logic [9:0] {
      S_CLEAR      = 10'b0000000001,
      S_IDLE       = 10'b0000000010,
      S_CHECK      = 10'b0000000100,
      S_SCAN_RD    = 10'b0000001000,
      S_SCAN_LD    = 10'b0000010000,
      S_SCAN_EV    = 10'b0000100000,
      S_EMIT_STOP  = 10'b0001000000,
      S_GAIN1      = 10'b0010000000,
      S_GAIN2      = 10'b0100000000,
      S_EMIT_START = 10'b1000000000
   } state_type;

   state_type              state_ff, state_in;
   pva_pkg::scan_mode_type mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         mode_ff  <= pva_pkg::SCAN_MIN;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mode  = mode_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_IDLE;
            case (sts.req_type)
               pva_pkg::REQ_LOAD: cmd.set_loaded = 1'b1;
               pva_pkg::REQ_PLAY: begin
                  if (sts.hit && sts.evict) begin
                     cmd.scan_init = 1'b1;
                     mode_in       = pva_pkg::SCAN_MIN;
                     state_in      = S_SCAN_RD;
                  end else if (sts.hit) begin
                     state_in = S_GAIN1;
                  end
               end
               pva_pkg::REQ_STOP, pva_pkg::REQ_UNLOAD: begin
                  if (sts.hit) begin
                     cmd.scan_init = 1'b1;
                     mode_in       = pva_pkg::SCAN_REMID;
                     state_in      = S_SCAN_RD;
                  end
               end
               pva_pkg::REQ_CLEANUP: begin
                  cmd.scan_init = 1'b1;
                  mode_in       = pva_pkg::SCAN_CLEAN;
                  state_in      = S_SCAN_RD;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SCAN_RD: begin
            if (sts.scan_end) begin
               case (mode_ff)
                  pva_pkg::SCAN_MIN: begin
                     cmd.scan_init = 1'b1;
                     mode_in       = pva_pkg::SCAN_REMAT;
                  end
                  pva_pkg::SCAN_REMAT: begin
                     cmd.scan_fin = 1'b1;
                     state_in     = S_EMIT_STOP;
                  end
                  pva_pkg::SCAN_REMID: begin
                     cmd.scan_fin   = 1'b1;
                     cmd.clr_loaded = (sts.req_type == pva_pkg::REQ_UNLOAD);
                     state_in       = S_EMIT_STOP;
                  end
                  default: begin
                     cmd.scan_fin = 1'b1;
                     state_in     = S_IDLE;
                  end
               endcase
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_LD;
            end
         end
         S_SCAN_LD: begin
            cmd.scan_ld = 1'b1;
            state_in    = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
            state_in    = S_SCAN_RD;
         end
         S_EMIT_STOP: begin
            if (sts.out_free) begin
               if (mode_ff == pva_pkg::SCAN_REMAT) begin
                  cmd.emit_victim = 1'b1;
                  state_in        = S_GAIN1;
               end else begin
                  cmd.emit_req_stop = 1'b1;
                  state_in          = S_IDLE;
               end
            end
         end
         S_GAIN1: begin
            cmd.gain1 = 1'b1;
            state_in  = S_GAIN2;
         end
         S_GAIN2: begin
            cmd.gain2 = 1'b1;
            state_in  = S_EMIT_START;
         end
         S_EMIT_START: begin
            if (sts.out_free) begin
               cmd.emit_start = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // A scan is only ever started from a decision state, never mid-scan.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_init |-> (state_ff == S_CHECK || state_ff == S_SCAN_RD))
      else $error("scan started from an unexpected state");
   // A request is taken only after the loaded map has been cleared.
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> sts.clear_done)
      else $error("request accepted during the clearing pass");
   // Every start result is preceded by both gain stages.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_start && $past(state_ff == S_GAIN2) |-> $past(cmd.gain1, 2))
      else $error("start emitted without a gain product");

endmodule
`default_nettype wire

// ----- rtl/core/pva_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pva_datapath
// Loaded map, voice table, scan counters, gain product and result register.
// ----------------------------------------------------------------------------
module pva_datapath #(
   parameter int CHANNELS      = pva_pkg::CHANNELS_DEFAULT,
   parameter int SOUND_SLOTS   = pva_pkg::SOUND_SLOTS_DEFAULT,
   parameter int PRIORITY_BITS = pva_pkg::PRIORITY_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pva_pkg::req_type_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pva_pkg::rsp_type           rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [2:0]            csr_index,
   input  wire logic [8:0]            csr_wdata,
   input  wire pva_pkg::cmd_type      cmd,
   output pva_pkg::status_type        sts
);

   localparam int LW = (SOUND_SLOTS > 1) ? $clog2(SOUND_SLOTS) : 1;
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NW = $clog2(CHANNELS + 1);

   typedef struct packed {
      logic [7:0]               id;
      logic [PRIORITY_BITS-1:0] pri;
      logic                     loop;
   } voice_type;

   logic [5:0] max_channels_ff;
   logic [8:0] master_gain_ff, effects_gain_ff, speech_gain_ff, music_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_channels_ff <= pva_pkg::MAX_CHANNELS_RESET;
         master_gain_ff  <= pva_pkg::GAIN_RESET;
         effects_gain_ff <= pva_pkg::GAIN_RESET;
         speech_gain_ff  <= pva_pkg::GAIN_RESET;
         music_gain_ff   <= pva_pkg::GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pva_pkg::CSR_MAX_CHANNELS: max_channels_ff <= csr_wdata[5:0];
            pva_pkg::CSR_MASTER_GAIN:  master_gain_ff  <= csr_wdata;
            pva_pkg::CSR_EFFECTS_GAIN: effects_gain_ff <= csr_wdata;
            pva_pkg::CSR_SPEECH_GAIN:  speech_gain_ff  <= csr_wdata;
            pva_pkg::CSR_MUSIC_GAIN:   music_gain_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   pva_pkg::req_type_type req_ff;
   voice_type             vq_ff;
   logic                  ld_q_ff;
   logic [LW-1:0]         clr_ff;
   logic                  clear_done_ff;
   logic [NW-1:0]         cnt_ff, cnt_in, r_ff, r_in, w_ff, w_in, best_ff;
   logic [PRIORITY_BITS-1:0] best_pri_ff;
   logic [7:0]            victim_ff;
   logic [17:0]           p1_ff;
   logic [26:0]           p2_ff;
   logic                  out_valid_ff, out_valid_in;
   pva_pkg::rsp_type      out_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
   end

   // Loaded map.
   logic              loaded_mem [SOUND_SLOTS];
   logic              ld_we, ld_wdata, ld_re;
   logic [LW-1:0]     ld_waddr, ld_raddr;
   logic              req_id_ok, vq_id_ok, keep, better;
   logic [8:0]        lim, cnt9, cat_gain;
   logic [10:0]       gain_shift;
   logic [8:0]        gain_sat;

   assign req_id_ok = (32'(req_ff.sound_id) < SOUND_SLOTS);
   assign vq_id_ok  = (32'(vq_ff.id) < SOUND_SLOTS);

   always_comb begin
      ld_we    = 1'b0;
      ld_wdata = 1'b0;
      ld_waddr = LW'(req_ff.sound_id);
      if (!clear_done_ff) begin
         ld_we    = 1'b1;
         ld_waddr = clr_ff;
      end else if (cmd.set_loaded && req_id_ok) begin
         ld_we    = 1'b1;
         ld_wdata = 1'b1;
      end else if (cmd.clr_loaded) begin
         ld_we = 1'b1;
      end
      ld_re    = cmd.capture || cmd.scan_ld;
      ld_raddr = cmd.scan_ld ? LW'(vq_ff.id) : LW'(req_data.sound_id);
   end

   always_ff @(posedge clock) begin
      if (ld_we) loaded_mem[ld_waddr] <= ld_wdata;
      if (ld_re) ld_q_ff <= loaded_mem[ld_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         clear_done_ff <= 1'b0;
      end else if (!clear_done_ff) begin
         clr_ff        <= clr_ff + 1'b1;
         clear_done_ff <= (clr_ff == LW'(SOUND_SLOTS - 1));
      end
   end

   // Voice table.
   voice_type voice_mem [CHANNELS];
   logic      vm_we;
   logic [CW-1:0] vm_waddr;
   voice_type vm_wdata;

   always_comb begin
      better = (r_ff == '0) || (vq_ff.pri < best_pri_ff);
      case (cmd.mode)
         pva_pkg::SCAN_REMAT: keep = (r_ff != best_ff);
         pva_pkg::SCAN_REMID: keep = (vq_ff.id != req_ff.sound_id);
         pva_pkg::SCAN_CLEAN: keep = vq_ff.loop || (vq_id_ok && ld_q_ff);
         default:             keep = 1'b0;
      endcase
      vm_we    = 1'b0;
      vm_waddr = w_ff[CW-1:0];
      vm_wdata = vq_ff;
      if (cmd.gain2 && (32'(cnt_ff) < CHANNELS)) begin
         vm_we         = 1'b1;
         vm_waddr      = cnt_ff[CW-1:0];
         vm_wdata.id   = req_ff.sound_id;
         vm_wdata.pri  = PRIORITY_BITS'(req_ff.priority_in);
         vm_wdata.loop = req_ff.loop_in;
      end else if (cmd.scan_ev && keep) begin
         vm_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (vm_we) voice_mem[vm_waddr] <= vm_wdata;
      if (cmd.scan_rd) vq_ff <= voice_mem[r_ff[CW-1:0]];
   end

   always_comb begin
      r_in   = r_ff;
      w_in   = w_ff;
      cnt_in = cnt_ff;
      if (cmd.scan_init) begin
         r_in = '0;
         w_in = '0;
      end else if (cmd.scan_ev) begin
         r_in = r_ff + 1'b1;
         if (keep) w_in = w_ff + 1'b1;
      end
      if (cmd.scan_fin) cnt_in = w_ff;
      else if (cmd.gain2 && (32'(cnt_ff) < CHANNELS)) cnt_in = cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         r_ff   <= '0;
         w_ff   <= '0;
      end else begin
         cnt_ff <= cnt_in;
         r_ff   <= r_in;
         w_ff   <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_ev && cmd.mode == pva_pkg::SCAN_MIN && better) begin
         best_ff     <= r_ff;
         best_pri_ff <= vq_ff.pri;
         victim_ff   <= vq_ff.id;
      end
   end

   // Eviction limit and gain product.
   always_comb begin
      lim = (max_channels_ff == '0) ? 9'd1 : 9'(max_channels_ff);
      if (32'(lim) > CHANNELS) lim = 9'(CHANNELS);
      cnt9 = 9'(cnt_ff);
      case (req_ff.category)
         pva_pkg::CAT_SPEECH: cat_gain = speech_gain_ff;
         pva_pkg::CAT_MUSIC:  cat_gain = music_gain_ff;
         default:             cat_gain = effects_gain_ff;
      endcase
      gain_shift = p2_ff[26:16];
      gain_sat   = (gain_shift > 11'(pva_pkg::GAIN_UNITY)) ? pva_pkg::GAIN_UNITY
                                                          : gain_shift[8:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.gain1) p1_ff <= master_gain_ff * cat_gain;
      if (cmd.gain2) p2_ff <= p1_ff * 27'(req_ff.event_gain);
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.emit_victim || cmd.emit_req_stop || cmd.emit_start) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_victim || cmd.emit_req_stop) begin
         out_ff.action       <= pva_pkg::ACT_STOP;
         out_ff.out_sound_id <= cmd.emit_victim ? victim_ff : req_ff.sound_id;
         out_ff.out_gain     <= '0;
         out_ff.out_loop     <= 1'b0;
         out_ff.active_count <= 6'(cnt_ff);
         out_ff.last         <= cmd.emit_req_stop;
      end else if (cmd.emit_start) begin
         out_ff.action       <= pva_pkg::ACT_START;
         out_ff.out_sound_id <= req_ff.sound_id;
         out_ff.out_gain     <= gain_sat;
         out_ff.out_loop     <= req_ff.loop_in;
         out_ff.active_count <= 6'(cnt_ff);
         out_ff.last         <= 1'b1;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign sts.clear_done = clear_done_ff;
   assign sts.req_type   = req_ff.req_type;
   assign sts.hit        = req_id_ok && ld_q_ff;
   assign sts.evict      = (cnt9 >= lim) && (cnt_ff != '0);
   assign sts.scan_end   = (r_ff >= cnt_ff);
   assign sts.out_free   = !out_valid_ff || rsp_ready;

   // Compaction never writes ahead of the entry being read.
   assert property (@(posedge clock) disable iff (reset) w_ff <= r_ff)
      else $error("compaction write index passed the read index");
   // The table never holds more entries than it has storage for.
   assert property (@(posedge clock) disable iff (reset) 32'(cnt_ff) <= CHANNELS)
      else $error("voice count above table depth");
   // An eviction pass always removes exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_fin && cmd.mode == pva_pkg::SCAN_REMAT |-> w_ff + 1'b1 == cnt_ff)
      else $error("eviction did not remove exactly one entry");

endmodule
`default_nettype wire
